// File: src/pmst_pkg.sv
// shared constants and types for the prim spanning tree unit
package pmst_pkg;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int KEY_W            = 10;
  localparam int VC_W             = 5;
  localparam int VERT_OUT_W       = 4;

  localparam logic [KEY_W-1:0] KEY_INIT     = 10'd1000;
  localparam logic [VC_W-1:0]  VCOUNT_RESET = 5'd16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RELAX,
    ST_OUT_NODE,
    ST_OUT_WT,
    ST_OUT_LOAD
  } pmst_state_t;

endpackage

// File: src/prim_minimum_spanning_tree_unit.sv
// prim minimum spanning tree over an adjacency weight matrix
//
// in channel (valid/ready): operation 0 writes one edge weight into the
// matrix (taken one beat per cycle while idle, no result), operation 1 runs
// the tree from start_vertex over n = vertex_count vertices (clamped to
// 1..MAX_VERTICES). a run with start out of range or n = 1 gives no result.
// cfg channel: vertex_count, always ready; write it only while idle.
// out channel (valid/ready): n-1 beats per run, children start+1 wrapping
// round to start-1, last set on the final beat.
// a run: the vertex table is set up first, then n rounds of a linear min
// scan plus a relax sweep, all through the one read port of the vertex
// table; then each result beat takes a vertex read, a weight read and a
// load. in_ready is low for the whole run.
// reset: the weight matrix is swept to zero, one entry a cycle, over all
// (2^clog2(MAX_VERTICES))^2 entries (256 by default) with in_ready low.
// a stalled receiver holds the result register; the sequencer waits on it.
module prim_minimum_spanning_tree_unit
  import pmst_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [VC_W-1:0]       cfg_vertex_count,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [3:0]            in_from_vertex,
  input  logic [3:0]            in_to_vertex,
  input  logic [KEY_W-1:0]      in_edge_weight_in,
  input  logic [3:0]            in_start_vertex,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VERT_OUT_W-1:0] out_parent_vertex,
  output logic [VERT_OUT_W-1:0] out_child_vertex,
  output logic [KEY_W-1:0]      out_tree_edge_weight,
  output logic                  out_reached,
  output logic                  out_last
);

  localparam int VW      = $clog2(MAX_VERTICES);
  localparam int CW      = $clog2(MAX_VERTICES + 1);
  localparam int CMPW    = (CW > VC_W) ? CW : VC_W;
  localparam int NODE_W  = KEY_W + VW + 2;
  localparam int WADDR_W = 2 * VW;

  pmst_state_t state_r, state_nxt;

  logic [VC_W-1:0]    vcount_r;
  logic [WADDR_W-1:0] clr_cnt_r;
  logic [CW-1:0]      n_r;
  logic [VW-1:0]      start_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      it_r;
  logic [KEY_W-1:0]   best_key_r;
  logic [VW-1:0]      best_idx_r;
  logic               pend_r;
  logic [VW-1:0]      pidx_r;
  logic [VW-1:0]      ov_r;
  logic [VW-1:0]      par_r;
  logic               pset_r;

  logic                  out_valid_r;
  logic [VERT_OUT_W-1:0] out_parent_r;
  logic [VERT_OUT_W-1:0] out_child_r;
  logic [KEY_W-1:0]      out_weight_r;
  logic                  out_reached_r;
  logic                  out_last_r;

  // vertex table: {key, parent, parent set, in tree}
  logic              node_we, node_re;
  logic [VW-1:0]     node_waddr, node_raddr;
  logic [NODE_W-1:0] node_wdata, node_q;
  logic [KEY_W-1:0]  q_key;
  logic [VW-1:0]     q_par;
  logic              q_pset, q_intree;

  logic               w_we, w_re;
  logic [WADDR_W-1:0] w_waddr, w_raddr;
  logic [KEY_W-1:0]   w_wdata, w_q;

  logic [CMPW-1:0] vc_ext, s_inc;
  logic [CW-1:0]   n_eff, ov_inc;
  logic [VW-1:0]   cnt_idx, ov_wrap, start_wrap;
  logic            cnt_last, init_last, run_ok, edge_ok, in_beat;
  logic            scan_take, relax_upd, out_free, ov_last, iter_last;

  assign q_key    = node_q[NODE_W-1:VW+2];
  assign q_par    = node_q[VW+1:2];
  assign q_pset   = node_q[1];
  assign q_intree = node_q[0];

  // effective vertex count, 0 acts as 1 and large values clamp
  always_comb begin
    vc_ext = CMPW'(vcount_r);
    if (vc_ext == '0) begin
      n_eff = CW'(1);
    end else if (vc_ext > CMPW'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vc_ext);
    end
  end

  assign in_beat = in_valid && in_ready;
  assign run_ok  = (in_operation == OP_RUN) &&
                   (CMPW'(in_start_vertex) < CMPW'(n_eff)) && (n_eff != CW'(1));
  assign edge_ok = (in_operation == OP_WRITE) &&
                   (CMPW'(in_from_vertex) < CMPW'(MAX_VERTICES)) &&
                   (CMPW'(in_to_vertex) < CMPW'(MAX_VERTICES));

  assign s_inc      = CMPW'(in_start_vertex) + CMPW'(1);
  assign start_wrap = (s_inc == CMPW'(n_eff)) ? '0 : VW'(s_inc);

  assign cnt_idx   = cnt_r[VW-1:0];
  assign cnt_last  = (cnt_r == n_r);
  assign init_last = (cnt_r == n_r - CW'(1));
  assign iter_last = (it_r == n_r - CW'(1));

  assign ov_inc  = CW'(ov_r) + CW'(1);
  assign ov_wrap = (ov_inc == n_r) ? '0 : ov_inc[VW-1:0];
  assign ov_last = (ov_wrap == start_r);

  assign scan_take = pend_r && !q_intree && (q_key < best_key_r);
  assign relax_upd = pend_r && !q_intree && (w_q != '0) && (w_q < q_key);
  assign out_free  = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (&clr_cnt_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && run_ok) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        if (init_last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_last) state_nxt = ST_MARK_RD;
      end
      ST_MARK_RD:  state_nxt = ST_MARK_WR;
      ST_MARK_WR:  state_nxt = ST_RELAX;
      ST_RELAX: begin
        if (cnt_last) state_nxt = iter_last ? ST_OUT_NODE : ST_SCAN;
      end
      ST_OUT_NODE: state_nxt = ST_OUT_WT;
      ST_OUT_WT:   state_nxt = ST_OUT_LOAD;
      ST_OUT_LOAD: begin
        if (out_free) state_nxt = ov_last ? ST_IDLE : ST_OUT_NODE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    in_ready   = 1'b0;
    node_we    = 1'b0;
    node_waddr = cnt_idx;
    node_wdata = '0;
    node_re    = 1'b0;
    node_raddr = cnt_idx;
    w_we       = 1'b0;
    w_waddr    = clr_cnt_r;
    w_wdata    = '0;
    w_re       = 1'b0;
    w_raddr    = {best_idx_r, cnt_idx};
    case (state_r)
      ST_CLEAR: begin
        w_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        w_we     = in_valid && edge_ok;
        w_waddr  = {VW'(in_from_vertex), VW'(in_to_vertex)};
        w_wdata  = in_edge_weight_in;
      end
      ST_INIT: begin
        node_we    = 1'b1;
        node_wdata = {((cnt_idx == start_r) ? KEY_W'(0) : KEY_INIT), VW'(0), 2'b00};
      end
      ST_SCAN: begin
        node_re = !cnt_last;
      end
      ST_MARK_RD: begin
        node_re    = 1'b1;
        node_raddr = best_idx_r;
      end
      ST_MARK_WR: begin
        node_we    = 1'b1;
        node_waddr = best_idx_r;
        node_wdata = {node_q[NODE_W-1:1], 1'b1};
      end
      ST_RELAX: begin
        node_re    = !cnt_last;
        w_re       = !cnt_last;
        node_we    = relax_upd;
        node_waddr = pidx_r;
        node_wdata = {w_q, best_idx_r, 2'b10};
      end
      ST_OUT_NODE: begin
        node_re    = 1'b1;
        node_raddr = ov_r;
      end
      ST_OUT_WT: begin
        w_re    = 1'b1;
        w_raddr = {q_par, ov_r};
      end
      ST_OUT_LOAD: begin
        w_raddr = {par_r, ov_r};
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      vcount_r    <= VCOUNT_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        vcount_r <= cfg_vertex_count;
      end
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + WADDR_W'(1);
      end
      pend_r <= ((state_r == ST_SCAN) || (state_r == ST_RELAX)) && !cnt_last;
      if ((state_r == ST_OUT_LOAD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= cnt_idx;
    if (state_r != state_nxt) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + CW'(1);
    end
    if ((state_r == ST_IDLE) && in_beat && run_ok) begin
      n_r     <= n_eff;
      start_r <= VW'(in_start_vertex);
      ov_r    <= start_wrap;
      it_r    <= '0;
    end
    // fresh min search each round
    if (state_nxt == ST_SCAN && state_r != ST_SCAN) begin
      best_key_r <= KEY_INIT;
      best_idx_r <= '0;
    end else if ((state_r == ST_SCAN) && scan_take) begin
      best_key_r <= q_key;
      best_idx_r <= pidx_r;
    end
    if ((state_r == ST_RELAX) && cnt_last) begin
      it_r <= it_r + CW'(1);
    end
    if (state_r == ST_OUT_WT) begin
      par_r  <= q_par;
      pset_r <= q_pset;
    end
    if ((state_r == ST_OUT_LOAD) && out_free) begin
      out_parent_r  <= pset_r ? VERT_OUT_W'(par_r) : '0;
      out_child_r   <= VERT_OUT_W'(ov_r);
      out_weight_r  <= pset_r ? w_q : '0;
      out_reached_r <= pset_r;
      out_last_r    <= ov_last;
      ov_r          <= ov_wrap;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_parent_vertex    = out_parent_r;
  assign out_child_vertex     = out_child_r;
  assign out_tree_edge_weight = out_weight_r;
  assign out_reached          = out_reached_r;
  assign out_last             = out_last_r;

  pmst_ram #(
    .WIDTH (NODE_W),
    .DEPTH (1 << VW)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_q)
  );

  pmst_ram #(
    .WIDTH (KEY_W),
    .DEPTH (1 << WADDR_W)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_q)
  );

  // an unreached child carries no parent and no weight
  a_unreached_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reached |-> (out_tree_edge_weight == '0) && (out_parent_vertex == '0))
    else $error("unreached child with nonzero parent or weight");

  // the picked vertex always lies inside the active vertex range
  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK_RD) |-> (CMPW'(best_idx_r) < CMPW'(n_r)))
    else $error("picked vertex out of range");

  // a new result beat only comes from the load step
  a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT_LOAD))
    else $error("result appeared outside the load step");

  // loading the last beat of a run returns the sequencer to idle
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT_LOAD) && out_free && ov_last |=> (state_r == ST_IDLE))
    else $error("result sequence continued past last beat");

endmodule

// File: src/pmst_ram.sv
// generic single write port, single read port ram with registered read
module pmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the prim spanning tree unit
`timescale 1ns / 100ps

module tb_top;
  import pmst_pkg::*;

  localparam int SETTLE_CYCLES = 800;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int ITEM_TARGET   = 310;
  localparam int PHASE_ITEMS   = 25;

  typedef struct packed {
    logic [3:0] parent;
    logic [3:0] child;
    logic [9:0] weight;
    logic       reached;
    logic       last;
  } tree_edge_t;

  class tree_scoreboard;
    logic [9:0]       weights [16][16];
    logic [VC_W-1:0]  vcount;
    tree_edge_t       expected_edges[$];
    int               errors;
    int               edge_writes;
    int               runs;
    int               empty_runs;
    int               edges_checked;
    int               unreached_seen;

    function new();
      for (int r = 0; r < 16; r++)
        for (int c = 0; c < 16; c++)
          weights[r][c] = '0;
      vcount = VCOUNT_RESET;
      errors = 0;
      edge_writes = 0;
      runs = 0;
      empty_runs = 0;
      edges_checked = 0;
      unreached_seen = 0;
    endfunction

    function int active_vertices();
      if (vcount == 0) return 1;
      if (vcount > 16) return 16;
      return int'(vcount);
    endfunction

    // prim over the first n vertices, then one tree edge per vertex after the root
    function void grow_tree(int root);
      int n, u, v, i, best, k;
      logic [9:0] key [16];
      logic [3:0] par [16];
      bit         has_par [16];
      bit         done [16];
      tree_edge_t e;
      n = active_vertices();
      runs++;
      if (root >= n) begin
        empty_runs++;
        return;
      end
      for (v = 0; v < n; v++) begin
        key[v] = KEY_INIT;
        par[v] = '0;
        has_par[v] = 0;
        done[v] = 0;
      end
      key[root] = '0;
      for (i = 0; i < n; i++) begin
        // nothing below the initial key left: falls back to vertex 0
        best = int'(KEY_INIT);
        u = 0;
        for (v = 0; v < n; v++)
          if (!done[v] && key[v] < best) begin
            best = int'(key[v]);
            u = v;
          end
        done[u] = 1;
        for (v = 0; v < n; v++)
          if (!done[v] && weights[u][v] != 0 && weights[u][v] < key[v]) begin
            par[v] = 4'(u);
            has_par[v] = 1;
            key[v] = weights[u][v];
          end
      end
      k = 0;
      v = (root + 1) % n;
      while (v != root) begin
        e.child   = 4'(v);
        e.reached = has_par[v];
        e.parent  = has_par[v] ? par[v] : 4'd0;
        e.weight  = has_par[v] ? weights[par[v]][v] : 10'd0;
        e.last    = (k == n - 2);
        expected_edges.push_back(e);
        k++;
        v = (v + 1) % n;
      end
      if (k == 0) empty_runs++;
    endfunction

    function void note_item(logic op, logic [3:0] from_v, logic [3:0] to_v,
                            logic [9:0] w, logic [3:0] root);
      if (op == OP_WRITE) begin
        weights[from_v][to_v] = w;
        edge_writes++;
      end else begin
        grow_tree(root);
      end
    endfunction

    function void check_result(logic [3:0] parent, logic [3:0] child, logic [9:0] w,
                               logic reached, logic last);
      tree_edge_t exp;
      if (expected_edges.size() == 0) begin
        $error("unexpected result beat: child %0d parent %0d", child, parent);
        errors++;
        return;
      end
      exp = expected_edges.pop_front();
      edges_checked++;
      if (!exp.reached) unreached_seen++;
      if (parent !== exp.parent) begin
        $error("parent_vertex: expected %0d, got %0d", exp.parent, parent);
        errors++;
      end
      if (child !== exp.child) begin
        $error("child_vertex: expected %0d, got %0d", exp.child, child);
        errors++;
      end
      if (w !== exp.weight) begin
        $error("tree_edge_weight: expected %0d, got %0d", exp.weight, w);
        errors++;
      end
      if (reached !== exp.reached) begin
        $error("reached: expected %0d, got %0d", exp.reached, reached);
        errors++;
      end
      if (last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [VC_W-1:0]       cfg_vertex_count;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_operation;
  logic [3:0]            in_from_vertex;
  logic [3:0]            in_to_vertex;
  logic [KEY_W-1:0]      in_edge_weight_in;
  logic [3:0]            in_start_vertex;
  logic                  out_valid;
  logic                  out_ready;
  logic [VERT_OUT_W-1:0] out_parent_vertex;
  logic [VERT_OUT_W-1:0] out_child_vertex;
  logic [KEY_W-1:0]      out_tree_edge_weight;
  logic                  out_reached;
  logic                  out_last;

  tree_scoreboard sb;
  int             cycles = 0;
  int             items_sent = 0;
  int             settings_used = 0;
  bit             in_holding = 0;
  bit             in_burst = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  prim_minimum_spanning_tree_unit #(
    .MAX_VERTICES(DEF_MAX_VERTICES)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_vertex_count     (cfg_vertex_count),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_operation         (in_operation),
    .in_from_vertex       (in_from_vertex),
    .in_to_vertex         (in_to_vertex),
    .in_edge_weight_in    (in_edge_weight_in),
    .in_start_vertex      (in_start_vertex),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_parent_vertex    (out_parent_vertex),
    .out_child_vertex     (out_child_vertex),
    .out_tree_edge_weight (out_tree_edge_weight),
    .out_reached          (out_reached),
    .out_last             (out_last)
  );

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function logic [9:0] random_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 10'd0;
    if (r < 20) return 10'($urandom_range(1000, 1023));
    if (r < 35) return 10'($urandom_range(1, 4));
    return 10'($urandom_range(1, 999));
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_parent_vertex, out_child_vertex, out_tree_edge_weight,
                      out_reached, out_last);
  end

  // receiver: random stalls with ready-only stretches in between
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(30, 120)) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // valid stays high across back-to-back beats, lowered here only for a gap
  task automatic send_item(logic op, logic [3:0] from_v, logic [3:0] to_v,
                           logic [9:0] w, logic [3:0] root);
    int gap;
    gap = in_burst ? 0 : pick_gap();
    if (gap > 0) begin
      if (in_holding) in_valid <= 1'b0;
      in_holding = 0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_from_vertex    <= from_v;
    in_to_vertex      <= to_v;
    in_edge_weight_in <= w;
    in_start_vertex   <= root;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, from_v, to_v, w, root);
    in_holding = 1;
    items_sent++;
  endtask

  task automatic write_edge(logic [3:0] from_v, logic [3:0] to_v, logic [9:0] w);
    send_item(OP_WRITE, from_v, to_v, w, 4'($urandom_range(0, 15)));
  endtask

  task automatic release_input();
    if (in_holding) in_valid <= 1'b0;
    in_holding = 0;
  endtask

  // waits for every expected result beat to be checked, then for the settle time
  task automatic wait_drained();
    release_input();
    while (sb.expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(logic [VC_W-1:0] val);
    wait_drained();
    cfg_valid        <= 1'b1;
    cfg_vertex_count <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.vcount = val;
    settings_used++;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase();
    int n, k, j, stop;
    logic [3:0] a, b;
    logic [9:0] w;
    n = sb.active_vertices();
    stop = items_sent + PHASE_ITEMS;
    in_burst = ($urandom_range(0, 3) == 0);
    while (items_sent < stop) begin
      if ($urandom_range(0, 4) != 0) begin
        // build a graph inside the active vertices, then grow a tree on it
        k = $urandom_range(1, (n < 6) ? 2 * n : 12);
        for (j = 0; j < k; j++) begin
          a = 4'($urandom_range(0, n - 1));
          b = 4'($urandom_range(0, n - 1));
          w = random_weight();
          write_edge(a, b, w);
          if ($urandom_range(0, 1) != 0) write_edge(b, a, w);
        end
        send_item(OP_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  10'($urandom_range(0, 1023)), 4'($urandom_range(0, n - 1)));
      end else begin
        send_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)),
                  4'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    logic [VC_W-1:0] settings [8];
    settings = '{5'd0, 5'd2, 5'd31, 5'd3, 5'd1, 5'd16, 5'd17, 5'd8};
    sb = new();
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_vertex_count  = '0;
    in_valid          = 1'b0;
    in_operation      = OP_WRITE;
    in_from_vertex    = '0;
    in_to_vertex      = '0;
    in_edge_weight_in = '0;
    in_start_vertex   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty matrix: nothing reachable, every child unreached
    send_item(OP_RUN, 4'd15, 4'd15, 10'd1023, 4'd0);
    write_edge(4'd0, 4'd1, 10'd1);
    write_edge(4'd1, 4'd0, 10'd1);
    write_edge(4'd1, 4'd2, 10'd999);
    write_edge(4'd2, 4'd3, 10'd1000);
    write_edge(4'd3, 4'd4, 10'd1023);
    // equal keys on 5 and 6: lower index wins
    write_edge(4'd0, 4'd5, 10'd3);
    write_edge(4'd0, 4'd6, 10'd3);
    write_edge(4'd5, 4'd6, 10'd2);
    write_edge(4'd15, 4'd14, 10'd5);
    write_edge(4'd14, 4'd15, 10'd7);
    send_item(OP_RUN, 4'd0, 4'd0, 10'd0, 4'd0);
    send_item(OP_RUN, 4'd0, 4'd0, 10'd0, 4'd15);
    send_item(OP_RUN, 4'd0, 4'd0, 10'd0, 4'd14);
    write_edge(4'd0, 4'd1, 10'd0);
    send_item(OP_RUN, 4'd0, 4'd0, 10'd0, 4'd1);

    foreach (settings[i]) begin
      set_vertex_count(settings[i]);
      random_phase();
    end
    while (items_sent < ITEM_TARGET) begin
      set_vertex_count(VC_W'($urandom_range(0, 31)));
      random_phase();
    end

    wait_drained();
    $display("summary: %0d beats in, %0d edge writes, %0d runs (%0d without result)",
             items_sent, sb.edge_writes, sb.runs, sb.empty_runs);
    $display("summary: %0d tree edges checked, %0d unreached, %0d vertex count settings",
             sb.edges_checked, sb.unreached_seen, settings_used);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
